FILE: hw/rtl/fss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fss_pkg: font size scaler shared definitions
// Size tables, field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int NUM_SIZES  = 15;
  localparam int IDX_W      = 4;
  localparam int DIM_W      = 12;
  localparam int PX_W       = 8;
  localparam int PROD_W     = DIM_W + PX_W;
  localparam int REQ_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [IDX_W-1:0] MAX_SIZE = IDX_W'(NUM_SIZES - 1);

  localparam logic [CFG_IDX_W-1:0] REG_SOFTKEY_MULT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOFTKEY_DIV  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_DIM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DESIGN_DIM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AVAIL_FONTS  = 3'd4;

  typedef logic [NUM_SIZES-1:0] size_mask_t;

  function automatic logic [PX_W-1:0] width_of(input logic [IDX_W-1:0] idx);
    logic [PX_W-1:0] w;
    case (idx)
      4'd0:    w = 8'd6;
      4'd1:    w = 8'd8;
      4'd2:    w = 8'd8;
      4'd3:    w = 8'd12;
      4'd4:    w = 8'd16;
      4'd5:    w = 8'd16;
      4'd6:    w = 8'd24;
      4'd7:    w = 8'd32;
      4'd8:    w = 8'd32;
      4'd9:    w = 8'd48;
      4'd10:   w = 8'd64;
      4'd11:   w = 8'd64;
      4'd12:   w = 8'd96;
      4'd13:   w = 8'd128;
      4'd14:   w = 8'd128;
      default: w = 8'd128;
    endcase
    return w;
  endfunction

  function automatic logic [PX_W-1:0] height_of(input logic [IDX_W-1:0] idx);
    logic [PX_W-1:0] h;
    case (idx)
      4'd0:    h = 8'd8;
      4'd1:    h = 8'd8;
      4'd2:    h = 8'd12;
      4'd3:    h = 8'd16;
      4'd4:    h = 8'd16;
      4'd5:    h = 8'd24;
      4'd6:    h = 8'd32;
      4'd7:    h = 8'd32;
      4'd8:    h = 8'd48;
      4'd9:    h = 8'd64;
      4'd10:   h = 8'd64;
      4'd11:   h = 8'd96;
      4'd12:   h = 8'd128;
      4'd13:   h = 8'd128;
      4'd14:   h = 8'd192;
      default: h = 8'd192;
    endcase
    return h;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/font_size_scaler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// font_size_scaler
// Scales a requested font size by a configured ratio and picks the nearest
// supported size at or below the scaled fit.
// ----------------------------------------------------------------------------
// Usage:
//   Request: pulse start with font_size and use_softkey_scale; the beat is
//   taken at a rising edge where start is high and busy is low. busy is high
//   only right after reset, so one request can be taken every cycle.
//   Result: done is high for exactly one cycle with scaled_index, width_px
//   and height_px; the receiver must take it then, it cannot stall the block.
//   Throughput: one beat per cycle through a five-register pipeline
//   (operand select, two products, table compares, index pick, step down
//   to an available size with table lookup).
//   The scaled value floor((mult*px << frac) / div) is never formed: an
//   entry fits when entry * div <= mult * px, which needs no divider.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high. Write only while no request is in flight.
//   Reset (rst, synchronous): clears the pipeline valid bits and sets all
//   configuration registers to 1.
// ----------------------------------------------------------------------------
module font_size_scaler (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [fss_pkg::REQ_W-1:0]       font_size,
  input  wire logic                            use_softkey_scale,
  output logic                                 done,
  output logic [fss_pkg::IDX_W-1:0]            scaled_index,
  output logic [fss_pkg::PX_W-1:0]             width_px,
  output logic [fss_pkg::PX_W-1:0]             height_px,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fss_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [fss_pkg::DIM_W-1:0] softkey_scale_mult;
  logic [fss_pkg::DIM_W-1:0] softkey_scale_div;
  logic [fss_pkg::DIM_W-1:0] screen_dim;
  logic [fss_pkg::DIM_W-1:0] design_dim;
  fss_pkg::size_mask_t       available_fonts;

  logic accept;

  // stage 1: clamped index and selected ratio
  logic                      v1;
  logic [fss_pkg::IDX_W-1:0] idx1;
  logic [fss_pkg::DIM_W-1:0] mult1;
  logic [fss_pkg::DIM_W-1:0] div1;

  // stage 2: scaled products
  logic                       v2;
  logic [fss_pkg::PROD_W-1:0] pw2;
  logic [fss_pkg::PROD_W-1:0] ph2;
  logic [fss_pkg::DIM_W-1:0]  div2;

  // stage 3: fit vectors
  logic                v3;
  fss_pkg::size_mask_t wfit3;
  fss_pkg::size_mask_t hfit3;
  fss_pkg::size_mask_t wfit_next;
  fss_pkg::size_mask_t hfit_next;

  // stage 4: fitted index
  logic                      v4;
  logic [fss_pkg::IDX_W-1:0] fit4;
  logic [fss_pkg::IDX_W-1:0] fit_next;

  logic [fss_pkg::IDX_W-1:0] pick_next;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // hold off start while reset is applied
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      softkey_scale_mult <= fss_pkg::DIM_W'(1);
      softkey_scale_div  <= fss_pkg::DIM_W'(1);
      screen_dim         <= fss_pkg::DIM_W'(1);
      design_dim         <= fss_pkg::DIM_W'(1);
      available_fonts    <= fss_pkg::NUM_SIZES'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fss_pkg::REG_SOFTKEY_MULT: softkey_scale_mult <= cfg_data[fss_pkg::DIM_W-1:0];
        fss_pkg::REG_SOFTKEY_DIV:  softkey_scale_div  <= cfg_data[fss_pkg::DIM_W-1:0];
        fss_pkg::REG_SCREEN_DIM:   screen_dim         <= cfg_data[fss_pkg::DIM_W-1:0];
        fss_pkg::REG_DESIGN_DIM:   design_dim         <= cfg_data[fss_pkg::DIM_W-1:0];
        fss_pkg::REG_AVAIL_FONTS:  available_fonts    <= cfg_data[fss_pkg::NUM_SIZES-1:0];
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (font_size > fss_pkg::REQ_W'(fss_pkg::MAX_SIZE)) begin
      idx1 <= fss_pkg::MAX_SIZE;
    end else begin
      idx1 <= font_size[fss_pkg::IDX_W-1:0];
    end
    mult1 <= use_softkey_scale ? softkey_scale_mult : screen_dim;
    div1  <= use_softkey_scale ? softkey_scale_div  : design_dim;
  end

  // stage 2
  always_ff @(posedge clk) begin
    pw2  <= fss_pkg::PROD_W'(mult1) * fss_pkg::PROD_W'(fss_pkg::width_of(idx1));
    ph2  <= fss_pkg::PROD_W'(mult1) * fss_pkg::PROD_W'(fss_pkg::height_of(idx1));
    div2 <= div1;
  end

  // entry i fits when entry * div <= scaled product; a zero divisor fits all
  always_comb begin
    for (int i = 0; i < fss_pkg::NUM_SIZES; i++) begin
      wfit_next[i] = (fss_pkg::PROD_W'(fss_pkg::width_of(fss_pkg::IDX_W'(i))) *
                      fss_pkg::PROD_W'(div2)) <= pw2;
      hfit_next[i] = (fss_pkg::PROD_W'(fss_pkg::height_of(fss_pkg::IDX_W'(i))) *
                      fss_pkg::PROD_W'(div2)) <= ph2;
    end
  end

  always_ff @(posedge clk) begin
    wfit3 <= wfit_next;
    hfit3 <= hfit_next;
  end

  // tables rise monotonically, so the AND of both vectors tops out at the
  // smaller of the two fits; no fit at all drops to index 0
  always_comb begin
    fss_pkg::size_mask_t both;
    both     = wfit3 & hfit3;
    fit_next = '0;
    for (int i = 0; i < fss_pkg::NUM_SIZES; i++) begin
      if (both[i]) begin
        fit_next = fss_pkg::IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    fit4 <= fit_next;
  end

  // step down to the nearest available size, saturating at 0
  always_comb begin
    pick_next = '0;
    for (int i = 1; i < fss_pkg::NUM_SIZES; i++) begin
      if (available_fonts[i] && (fss_pkg::IDX_W'(i) <= fit4)) begin
        pick_next = fss_pkg::IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    scaled_index <= pick_next;
    width_px     <= fss_pkg::width_of(pick_next);
    height_px    <= fss_pkg::height_of(pick_next);
  end

  // assertions
  a_fit_monotonic: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (((wfit3 & (wfit3 >> 1)) == (wfit3 >> 1)) &&
            ((hfit3 & (hfit3 >> 1)) == (hfit3 >> 1))))
    else $error("fit vector not monotonic");

  a_pick_available: assert property (@(posedge clk) disable iff (rst)
    done |-> (scaled_index == '0 ||
              (scaled_index <= fss_pkg::MAX_SIZE && available_fonts[scaled_index])))
    else $error("result index is not an available size");

  a_pick_below_fit: assert property (@(posedge clk) disable iff (rst)
    done |-> scaled_index <= $past(fit4))
    else $error("result index above fitted index");

  a_dims_match: assert property (@(posedge clk) disable iff (rst)
    done |-> (width_px == fss_pkg::width_of(scaled_index) &&
              height_px == fss_pkg::height_of(scaled_index)))
    else $error("result dimensions do not match index");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule
`default_nettype wire

FILE: tb/font_size_scaler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// font_size_scaler_tb: self-checking bench for the font size scaler
// Sends size requests with random gaps and predicts each pick from its own
// copy of the ratio registers and the availability mask. Every result beat
// is checked in order against that prediction. A short directed set comes
// first, then randomized phases with fresh register settings between them.
// ----------------------------------------------------------------------------
module font_size_scaler_tb;

  localparam int FRAC_BITS = 10;
  localparam int LATENCY   = 5;
  localparam int N_PHASES  = 12;
  localparam int PHASE_LEN = 153;
  localparam int MAX_PRINT = 50;

  // indexes with no register behind them; writes there must change nothing
  localparam logic [fss_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [fss_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  localparam logic [0:fss_pkg::NUM_SIZES-1][fss_pkg::PX_W-1:0] WIDTH_TBL = {
    8'd6, 8'd8, 8'd8, 8'd12, 8'd16, 8'd16, 8'd24, 8'd32,
    8'd32, 8'd48, 8'd64, 8'd64, 8'd96, 8'd128, 8'd128};
  localparam logic [0:fss_pkg::NUM_SIZES-1][fss_pkg::PX_W-1:0] HEIGHT_TBL = {
    8'd8, 8'd8, 8'd12, 8'd16, 8'd16, 8'd24, 8'd32, 8'd32,
    8'd48, 8'd64, 8'd64, 8'd96, 8'd128, 8'd128, 8'd192};

  typedef struct {
    logic [fss_pkg::REQ_W-1:0] code;
    logic                      softkey;
    logic                      drain;
  } size_req_t;

  typedef struct {
    logic [fss_pkg::IDX_W-1:0] idx;
    logic [fss_pkg::PX_W-1:0]  width;
    logic [fss_pkg::PX_W-1:0]  height;
  } font_pick_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  logic [fss_pkg::REQ_W-1:0]      font_size = '0;
  logic                           use_softkey_scale = 1'b0;
  logic                           done;
  logic [fss_pkg::IDX_W-1:0]      scaled_index;
  logic [fss_pkg::PX_W-1:0]       width_px;
  logic [fss_pkg::PX_W-1:0]       height_px;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [fss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fss_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // shadow copies of the ratio registers and the mask, reset values
  logic [fss_pkg::DIM_W-1:0] sk_mult = fss_pkg::DIM_W'(1);
  logic [fss_pkg::DIM_W-1:0] sk_div  = fss_pkg::DIM_W'(1);
  logic [fss_pkg::DIM_W-1:0] scr_dim = fss_pkg::DIM_W'(1);
  logic [fss_pkg::DIM_W-1:0] dsn_dim = fss_pkg::DIM_W'(1);
  fss_pkg::size_mask_t       avail_mask = fss_pkg::size_mask_t'(1);

  size_req_t  pending_reqs[$];
  font_pick_t expected_picks[$];

  size_req_t  next_req;
  font_pick_t want;
  logic       taken;
  bit         no_gaps;
  int         gap_left;
  int         errors;
  int         n_sent;
  int         n_checked;
  int         n_cfg_writes;

  font_size_scaler dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .font_size         (font_size),
    .use_softkey_scale (use_softkey_scale),
    .done              (done),
    .scaled_index      (scaled_index),
    .width_px          (width_px),
    .height_px         (height_px),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("timeout: %0d requests sent, %0d results checked", n_sent, n_checked);
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (errors < MAX_PRINT) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
    errors++;
  endtask

  function automatic longint unsigned scaled_px(input logic [fss_pkg::PX_W-1:0] px,
                                                input logic [fss_pkg::DIM_W-1:0] mul,
                                                input logic [fss_pkg::DIM_W-1:0] dv);
    longint unsigned prod;
    prod = mul;
    prod = (prod * px) << FRAC_BITS;
    // zero divisor saturates so every size fits
    if (dv == '0) return '1;
    return prod / dv;
  endfunction

  function automatic font_pick_t pick_font(input logic [fss_pkg::REQ_W-1:0] code,
                                           input logic softkey);
    logic [fss_pkg::IDX_W-1:0] req;
    logic [fss_pkg::DIM_W-1:0] mul;
    logic [fss_pkg::DIM_W-1:0] dv;
    longint unsigned           sw;
    longint unsigned           sh;
    int                        wi;
    int                        hi;
    int                        idx;
    font_pick_t                p;
    req = (code > fss_pkg::MAX_SIZE) ? fss_pkg::MAX_SIZE : code[fss_pkg::IDX_W-1:0];
    mul = softkey ? sk_mult : scr_dim;
    dv  = softkey ? sk_div : dsn_dim;
    sw  = scaled_px(WIDTH_TBL[req], mul, dv);
    sh  = scaled_px(HEIGHT_TBL[req], mul, dv);
    wi  = -1;
    hi  = -1;
    for (int i = 0; i < fss_pkg::NUM_SIZES; i++) begin
      if ((64'(WIDTH_TBL[i]) << FRAC_BITS) <= sw) wi = i;
      if ((64'(HEIGHT_TBL[i]) << FRAC_BITS) <= sh) hi = i;
    end
    if (wi < 0 || hi < 0) idx = 0;
    else idx = (wi < hi) ? wi : hi;
    // step down to a size the terminal has, stop at the smallest
    while (idx > 0 && !avail_mask[idx]) idx--;
    p.idx    = fss_pkg::IDX_W'(idx);
    p.width  = WIDTH_TBL[idx];
    p.height = HEIGHT_TBL[idx];
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [fss_pkg::DIM_W-1:0] rand_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return fss_pkg::DIM_W'(1);
      2:       return '1;
      3, 4, 5: return fss_pkg::DIM_W'($urandom_range(1, 16));
      6, 7:    return fss_pkg::DIM_W'($urandom_range(1, 64));
      default: return fss_pkg::DIM_W'($urandom_range(1, 4095));
    endcase
  endfunction

  function automatic fss_pkg::size_mask_t rand_mask();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return '0;
      2:       return fss_pkg::size_mask_t'(15'd1 << $urandom_range(0, fss_pkg::NUM_SIZES - 1));
      default: return fss_pkg::size_mask_t'($urandom);
    endcase
  endfunction

  // call at a rising edge; returns at the clock edge after the write beat
  task automatic write_reg(input logic [fss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fss_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fss_pkg::REG_SOFTKEY_MULT: sk_mult = data[fss_pkg::DIM_W-1:0];
      fss_pkg::REG_SOFTKEY_DIV:  sk_div = data[fss_pkg::DIM_W-1:0];
      fss_pkg::REG_SCREEN_DIM:   scr_dim = data[fss_pkg::DIM_W-1:0];
      fss_pkg::REG_DESIGN_DIM:   dsn_dim = data[fss_pkg::DIM_W-1:0];
      fss_pkg::REG_AVAIL_FONTS:  avail_mask = data[fss_pkg::NUM_SIZES-1:0];
      default: ;
    endcase
    n_cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [fss_pkg::CFG_DATA_W-1:0] mult_sk,
                          input logic [fss_pkg::CFG_DATA_W-1:0] div_sk,
                          input logic [fss_pkg::CFG_DATA_W-1:0] scr,
                          input logic [fss_pkg::CFG_DATA_W-1:0] dsn,
                          input logic [fss_pkg::CFG_DATA_W-1:0] mask);
    write_reg(fss_pkg::REG_SOFTKEY_MULT, mult_sk);
    write_reg(fss_pkg::REG_SOFTKEY_DIV, div_sk);
    write_reg(fss_pkg::REG_SCREEN_DIM, scr);
    write_reg(fss_pkg::REG_DESIGN_DIM, dsn);
    write_reg(fss_pkg::REG_AVAIL_FONTS, mask);
  endtask

  task automatic queue_req(input logic [fss_pkg::REQ_W-1:0] code, input logic softkey,
                           input logic drain);
    size_req_t r;
    r.code    = code;
    r.softkey = softkey;
    r.drain   = drain;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((pending_reqs.size() != 0 || start || expected_picks.size() != 0)
           && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic random_phase(input int n_items, input bit with_drain);
    int                        r;
    logic [fss_pkg::REQ_W-1:0] code;
    set_regs({3'($urandom), rand_dim()}, {3'($urandom), rand_dim()},
             {3'($urandom), rand_dim()}, {3'($urandom), rand_dim()},
             fss_pkg::CFG_DATA_W'(rand_mask()));
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 9);
      if (r < 7) code = fss_pkg::REQ_W'($urandom_range(0, fss_pkg::MAX_SIZE));
      else if (r < 9) code = fss_pkg::REQ_W'($urandom_range(15, 255));
      else code = fss_pkg::REQ_W'($urandom);
      queue_req(code, 1'($urandom_range(0, 1)),
                with_drain && (k == n_items / 2 || $urandom_range(0, 49) == 0));
    end
    wait_idle();
  endtask

  // driver: present the next request once the current beat is taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        expected_picks.push_back(pick_font(font_size, use_softkey_scale));
        n_sent++;
      end
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && expected_picks.size() != 0)) begin
          next_req = pending_reqs.pop_front();
          start             <= 1'b1;
          font_size         <= next_req.code;
          use_softkey_scale <= next_req.softkey;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done beat must match the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_picks.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: idx=%0d w=%0d h=%0d",
                                  scaled_index, width_px, height_px));
      end else begin
        want = expected_picks.pop_front();
        if (scaled_index !== want.idx)
          report_mismatch($sformatf("scaled_index %0d, expected %0d",
                                    scaled_index, want.idx));
        if (width_px !== want.width)
          report_mismatch($sformatf("width_px %0d, expected %0d", width_px, want.width));
        if (height_px !== want.height)
          report_mismatch($sformatf("height_px %0d, expected %0d",
                                    height_px, want.height));
        n_checked++;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: unit ratio and only the smallest size present
    no_gaps = 1'b1;
    queue_req(fss_pkg::REQ_W'(0), 1'b0, 1'b0);
    queue_req(fss_pkg::REQ_W'(255), 1'b1, 1'b0);
    wait_idle();

    // soft-key ratio 3/2, screen ratio 1/1, all sizes present
    set_regs(15'd3, 15'd2, 15'd1, 15'd1, 15'h7FFF);
    no_gaps = 1'b0;
    queue_req(fss_pkg::REQ_W'(0), 1'b1, 1'b0);
    queue_req(fss_pkg::REQ_W'(5), 1'b0, 1'b0);
    queue_req(fss_pkg::REQ_W'(9), 1'b1, 1'b0);
    queue_req(fss_pkg::REQ_W'(14), 1'b0, 1'b0);
    queue_req(fss_pkg::REQ_W'(14), 1'b1, 1'b0);
    queue_req(fss_pkg::REQ_W'(15), 1'b0, 1'b0);
    queue_req(fss_pkg::REQ_W'(255), 1'b1, 1'b0);
    queue_req(fss_pkg::REQ_W'(170), 1'b0, 1'b0);
    queue_req(fss_pkg::REQ_W'(85), 1'b1, 1'b0);
    wait_idle();

    // zero divisor on the soft-key side, zero multiplier on the screen side
    set_regs(15'd5, 15'd0, 15'd0, 15'd7, 15'h7FFF);
    queue_req(fss_pkg::REQ_W'(3), 1'b1, 1'b0);
    queue_req(fss_pkg::REQ_W'(0), 1'b1, 1'b0);
    queue_req(fss_pkg::REQ_W'(3), 1'b0, 1'b0);
    queue_req(fss_pkg::REQ_W'(14), 1'b0, 1'b0);
    wait_idle();

    // largest soft-key ratio, full-scale screen ratio 4095/4095, upper data bits set
    // on 12-bit registers, no size but the smallest, so every pick walks all the way down
    set_regs(15'h7FFF, 15'd1, 15'd4095, 15'h7FFF, 15'h0001);
    write_reg(REG_UNUSED_LO, 15'h7FFF);
    write_reg(REG_UNUSED_HI, 15'h2AAA);
    queue_req(fss_pkg::REQ_W'(14), 1'b1, 1'b0);
    queue_req(fss_pkg::REQ_W'(7), 1'b0, 1'b0);
    queue_req(fss_pkg::REQ_W'(255), 1'b1, 1'b0);
    queue_req(fss_pkg::REQ_W'(1), 1'b0, 1'b0);
    wait_idle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      random_phase(PHASE_LEN, ph % 3 == 1);
    end

    wait_idle();
    if (expected_picks.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_picks.size()));
    $display("Sent %0d size requests, checked %0d results, %0d register writes.",
             n_sent, n_checked, n_cfg_writes);
    $display("Covered zero and full-scale ratio terms, sparse and empty size masks, "
             , "and codes above the largest size.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/fss_pkg.sv
hw/rtl/font_size_scaler.sv
tb/font_size_scaler_tb.sv
